[src/bounded_integer_stack_assert.svh]
// Assertion macros for the stack RTL (used in bis_ctrl).
// No dependencies.
`ifndef BOUNDED_INTEGER_STACK_ASSERT_SVH
`define BOUNDED_INTEGER_STACK_ASSERT_SVH

// same-cycle implication
`define BIS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define BIS_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

[src/bis_pkg.sv]
// Package for the bounded integer stack: sizes, command codes, memory
// request and response structs. No dependencies.
package bis_pkg;

  localparam int DEPTH      = 1024;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int ROW_W      = IDX_W - 1;
  localparam int BANK_DEPTH = DEPTH / 2;
  localparam int SIZE_W     = 11;
  localparam int DATA_W     = 32;
  localparam int CMD_W      = 4;
  localparam int APB_AW     = 3;

  localparam logic [SIZE_W-1:0] CAP_RESET    = 11'd1024;
  localparam logic              REG_CAPACITY = 1'b0;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH     = 4'd0,
    CMD_PUSH2    = 4'd1,
    CMD_POP      = 4'd2,
    CMD_POP2     = 4'd3,
    CMD_TOP      = 4'd4,
    CMD_GET      = 4'd5,
    CMD_SET      = 4'd6,
    CMD_CLEAR    = 4'd7,
    CMD_SET_SIZE = 4'd8
  } cmd_t;

  typedef struct packed {
    logic              we_even;
    logic              we_odd;
    logic [ROW_W-1:0]  wrow_even;
    logic [ROW_W-1:0]  wrow_odd;
    logic [DATA_W-1:0] wdata_even;
    logic [DATA_W-1:0] wdata_odd;
    logic              re;
    logic [ROW_W-1:0]  rrow_even;
    logic [ROW_W-1:0]  rrow_odd;
  } mem_req_t;

  typedef struct packed {
    logic              valid;
    logic              status;
    logic              a_mem;
    logic              b_mem;
    logic              a_odd;
    logic [DATA_W-1:0] a_val;
    logic [SIZE_W-1:0] size;
  } resp_t;

endpackage

[src/bis_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module bis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/bis_ctrl.sv]
// Command decode, fill register and bank request generation for the stack.
// Depends on bis_pkg and bounded_integer_stack_assert.svh.
`include "bounded_integer_stack_assert.svh"

module bis_ctrl import bis_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     accept,
  input  logic [CMD_W-1:0]         command,
  input  logic signed [DATA_W-1:0] value_a,
  input  logic signed [DATA_W-1:0] value_b,
  input  logic [SIZE_W-1:0]        position,
  input  logic [SIZE_W-1:0]        capacity,
  output mem_req_t                 req,
  output resp_t                    resp
);

  logic [SIZE_W-1:0] fill;
  logic [SIZE_W-1:0] fill_next;
  logic [SIZE_W-1:0] cap_eff;
  logic [SIZE_W:0]   fill_plus2;
  logic [SIZE_W-1:0] fill_m1;
  logic [SIZE_W-1:0] fill_m2;
  logic              refused;
  logic              wr0;
  logic              wr1;
  logic              rd_a;
  logic              rd_b;
  logic [IDX_W-1:0]  w0;
  logic [IDX_W-1:0]  w1;
  logic [IDX_W-1:0]  ea;
  logic [IDX_W-1:0]  eb;
  logic [DATA_W-1:0] a_val;
  logic              go;

  assign cap_eff    = (capacity > SIZE_W'(DEPTH)) ? SIZE_W'(DEPTH) : capacity;
  assign fill_plus2 = {1'b0, fill} + (SIZE_W+1)'(2);
  assign fill_m1    = fill - SIZE_W'(1);
  assign fill_m2    = fill - SIZE_W'(2);

  always_comb begin
    refused   = 1'b0;
    fill_next = fill;
    wr0       = 1'b0;
    wr1       = 1'b0;
    rd_a      = 1'b0;
    rd_b      = 1'b0;
    w0        = fill[IDX_W-1:0];
    ea        = fill_m1[IDX_W-1:0];
    a_val     = '0;
    case (cmd_t'(command))
      CMD_PUSH: begin
        if (fill >= cap_eff) begin
          refused = 1'b1;
        end else begin
          wr0       = 1'b1;
          fill_next = fill + SIZE_W'(1);
        end
      end
      CMD_PUSH2: begin
        if (fill_plus2 > {1'b0, cap_eff}) begin
          refused = 1'b1;
        end else begin
          wr0       = 1'b1;
          wr1       = 1'b1;
          fill_next = fill_plus2[SIZE_W-1:0];
        end
      end
      CMD_POP: begin
        if (fill == '0) begin
          refused = 1'b1;
        end else begin
          rd_a      = 1'b1;
          fill_next = fill_m1;
        end
      end
      CMD_POP2: begin
        if (fill < SIZE_W'(2)) begin
          refused = 1'b1;
        end else begin
          rd_a      = 1'b1;
          rd_b      = 1'b1;
          ea        = fill_m2[IDX_W-1:0];
          fill_next = fill_m2;
        end
      end
      CMD_TOP: begin
        if (fill == '0) begin
          refused = 1'b1;
        end else begin
          rd_a = 1'b1;
        end
      end
      CMD_GET: begin
        if (position >= fill) begin
          refused = 1'b1;
        end else begin
          rd_a = 1'b1;
          ea   = position[IDX_W-1:0];
        end
      end
      CMD_SET: begin
        if (position >= fill) begin
          refused = 1'b1;
        end else begin
          wr0   = 1'b1;
          w0    = position[IDX_W-1:0];
          a_val = value_a;
        end
      end
      CMD_CLEAR: begin
        fill_next = '0;
      end
      CMD_SET_SIZE: begin
        if (position > cap_eff) begin
          refused = 1'b1;
        end else begin
          fill_next = position;
        end
      end
      default: begin
        refused = 1'b1;
      end
    endcase
  end

  // entries alternate banks: bit 0 picks the bank, the rest the row
  assign go = accept & ~refused;
  assign w1 = w0 + IDX_W'(1);
  assign eb = ea + IDX_W'(1);

  always_comb begin
    req.we_even    = go & ((wr0 & ~w0[0]) | (wr1 & ~w1[0]));
    req.we_odd     = go & ((wr0 & w0[0]) | (wr1 & w1[0]));
    req.wrow_even  = w0[0] ? w1[IDX_W-1:1] : w0[IDX_W-1:1];
    req.wrow_odd   = w0[0] ? w0[IDX_W-1:1] : w1[IDX_W-1:1];
    req.wdata_even = w0[0] ? value_b : value_a;
    req.wdata_odd  = w0[0] ? value_a : value_b;
    req.re         = go & rd_a;
    req.rrow_even  = ea[0] ? eb[IDX_W-1:1] : ea[IDX_W-1:1];
    req.rrow_odd   = ea[0] ? ea[IDX_W-1:1] : eb[IDX_W-1:1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill       <= '0;
      resp.valid <= 1'b0;
    end else begin
      resp.valid <= accept;
      if (accept) begin
        fill <= fill_next;
      end
    end
    if (accept) begin
      resp.status <= refused;
      resp.a_mem  <= go & rd_a;
      resp.b_mem  <= go & rd_b;
      resp.a_odd  <= ea[0];
      resp.a_val  <= a_val;
      resp.size   <= fill_next;
    end
  end

  `BIS_ASSERT_IMP(a_fill_bound, clk, rst, 1'b1, fill <= SIZE_W'(DEPTH))
  `BIS_ASSERT_NXT(a_result_follows, clk, rst, accept, resp.valid)
  `BIS_ASSERT_NXT(a_refused_keeps_fill, clk, rst, accept && refused, fill == $past(fill))
  `BIS_ASSERT_IMP(a_write_needs_go, clk, rst, req.we_even || req.we_odd, accept && !refused)

endmodule

[src/bounded_integer_stack.sv]
// Top level of the bounded integer stack: APB register, bank memories, result mux.
// Depends on bis_pkg, bis_ctrl and bis_ram.
//
// One command is taken per clock cycle while busy is low; its result is on the
// result ports, with done high, in the cycle right after the command was taken.
// The result is registered in the response register and by the registered read
// of the even/odd entry memories, which together serve any two adjacent entries
// at once. busy is high only during reset. The receiver cannot stall: done is high
// for that single cycle only, and the result must be taken then.
module bounded_integer_stack import bis_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [CMD_W-1:0]         command,
  input  logic signed [DATA_W-1:0] value_a,
  input  logic signed [DATA_W-1:0] value_b,
  input  logic [SIZE_W-1:0]        position,
  output logic                     done,
  output logic                     status,
  output logic signed [DATA_W-1:0] result_a,
  output logic signed [DATA_W-1:0] result_b,
  output logic [SIZE_W-1:0]        size_now,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_AW-1:0]        paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  logic [SIZE_W-1:0] capacity;
  logic              accept;
  mem_req_t          req;
  resp_t             resp;
  logic [DATA_W-1:0] q_even;
  logic [DATA_W-1:0] q_odd;

  assign busy   = rst;
  assign accept = start & ~busy;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_CAPACITY) begin
      capacity <= pwdata[SIZE_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_CAPACITY) ? {{(32-SIZE_W){1'b0}}, capacity} : '0;

  bis_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .command  (command),
    .value_a  (value_a),
    .value_b  (value_b),
    .position (position),
    .capacity (capacity),
    .req      (req),
    .resp     (resp)
  );

  bis_ram #(.WIDTH(DATA_W), .DEPTH(BANK_DEPTH)) u_ram_even (
    .clk   (clk),
    .we    (req.we_even),
    .waddr (req.wrow_even),
    .wdata (req.wdata_even),
    .re    (req.re),
    .raddr (req.rrow_even),
    .rdata (q_even)
  );

  bis_ram #(.WIDTH(DATA_W), .DEPTH(BANK_DEPTH)) u_ram_odd (
    .clk   (clk),
    .we    (req.we_odd),
    .waddr (req.wrow_odd),
    .wdata (req.wdata_odd),
    .re    (req.re),
    .raddr (req.rrow_odd),
    .rdata (q_odd)
  );

  assign done     = resp.valid;
  assign status   = resp.status;
  assign size_now = resp.size;
  assign result_a = resp.a_mem ? (resp.a_odd ? q_odd : q_even) : resp.a_val;
  assign result_b = resp.b_mem ? (resp.a_odd ? q_even : q_odd) : '0;

endmodule

[test/tb.sv]
// Self-checking testbench for bounded_integer_stack: command driver, result monitor,
// an in-bench stack predictor, and APB writes of the capacity register between phases.
// Depends on bis_pkg and the bounded_integer_stack RTL.
module tb;
  import bis_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CMD_W-1:0] CMD_UNKNOWN_LO = 4'd9;
  localparam logic [CMD_W-1:0] CMD_UNKNOWN_HI = 4'd15;
  localparam int PLAN        = 0;  // shadow used while generating stimulus
  localparam int MIRROR      = 1;  // shadow advanced on each accepted transfer
  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_PHASES  = 11;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [DATA_W-1:0] value_a;
    logic [DATA_W-1:0] value_b;
    logic [SIZE_W-1:0] position;
  } stack_cmd_t;

  typedef struct packed {
    logic              status;
    logic [DATA_W-1:0] result_a;
    logic [DATA_W-1:0] result_b;
    logic [SIZE_W-1:0] size_now;
  } stack_result_t;

  logic                     clk;
  logic                     rst      = 1'b1;
  logic                     start    = 1'b0;
  logic                     busy;
  logic [CMD_W-1:0]         command  = '0;
  logic signed [DATA_W-1:0] value_a  = '0;
  logic signed [DATA_W-1:0] value_b  = '0;
  logic [SIZE_W-1:0]        position = '0;
  logic                     done;
  logic                     status;
  logic signed [DATA_W-1:0] result_a;
  logic signed [DATA_W-1:0] result_b;
  logic [SIZE_W-1:0]        size_now;
  logic                     psel     = 1'b0;
  logic                     penable  = 1'b0;
  logic                     pwrite   = 1'b0;
  logic [APB_AW-1:0]        paddr    = '0;
  logic [31:0]              pwdata   = '0;
  logic [31:0]              prdata;
  logic                     pready;

  bounded_integer_stack DUT (
    .clk, .rst, .start, .busy, .command, .value_a, .value_b, .position,
    .done, .status, .result_a, .result_b, .size_now,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  logic [DATA_W-1:0] stack_mem     [2][DEPTH];
  bit                stack_written [2][DEPTH];
  int                stack_fill    [2];
  int                stack_cap     [2];

  stack_cmd_t    cmd_backlog[$];
  stack_result_t answers_due[$];
  stack_cmd_t    on_port;
  int            gap_left   = 0;
  bit            idle_on    = 1'b1;
  int            errors     = 0;
  int            cycles     = 0;
  int            n_sent     = 0;
  int            n_results  = 0;
  int            n_refused  = 0;
  int            max_fill   = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void model_reset(input int m);
    for (int i = 0; i < DEPTH; i++) stack_written[m][i] = 1'b0;
    stack_fill[m] = 0;
    stack_cap[m]  = CAP_RESET;
  endfunction

  function automatic int eff_cap(input int m);
    return (stack_cap[m] < DEPTH) ? stack_cap[m] : DEPTH;
  endfunction

  function automatic void stack_put(input int m, input int idx, input logic [DATA_W-1:0] v);
    stack_mem[m][idx]     = v;
    stack_written[m][idx] = 1'b1;
  endfunction

  function automatic stack_result_t stack_step(input int m, input stack_cmd_t c);
    stack_result_t r;
    int f;
    int ecap;
    r    = '0;
    f    = stack_fill[m];
    ecap = eff_cap(m);
    case (c.command)
      CMD_PUSH: begin
        if (f >= ecap) r.status = 1'b1;
        else begin
          stack_put(m, f, c.value_a);
          f++;
        end
      end
      CMD_PUSH2: begin
        if (f + 2 > ecap) r.status = 1'b1;
        else begin
          stack_put(m, f, c.value_a);
          stack_put(m, f + 1, c.value_b);
          f += 2;
        end
      end
      CMD_POP: begin
        if (f == 0) r.status = 1'b1;
        else begin
          f--;
          r.result_a = stack_mem[m][f];
        end
      end
      CMD_POP2: begin
        if (f < 2) r.status = 1'b1;
        else begin
          r.result_b = stack_mem[m][f-1];
          r.result_a = stack_mem[m][f-2];
          f -= 2;
        end
      end
      CMD_TOP: begin
        if (f == 0) r.status = 1'b1;
        else r.result_a = stack_mem[m][f-1];
      end
      CMD_GET: begin
        if (c.position >= f) r.status = 1'b1;
        else r.result_a = stack_mem[m][c.position];
      end
      CMD_SET: begin
        if (c.position >= f) r.status = 1'b1;
        else begin
          stack_put(m, c.position, c.value_a);
          r.result_a = c.value_a;
        end
      end
      CMD_CLEAR: f = 0;
      CMD_SET_SIZE: begin
        if (c.position > ecap) r.status = 1'b1;
        else f = c.position;
      end
      default: r.status = 1'b1;
    endcase
    stack_fill[m] = f;
    r.size_now    = f[SIZE_W-1:0];
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic stack_cmd_t cmd_of(input logic [CMD_W-1:0] op, input logic [DATA_W-1:0] a,
                                        input logic [DATA_W-1:0] b, input int pos);
    stack_cmd_t c;
    c.command  = op;
    c.value_a  = a;
    c.value_b  = b;
    c.position = pos[SIZE_W-1:0];
    return c;
  endfunction

  // Picks a command from the planning shadow; reads of never-written entries
  // are turned into a set of that entry.
  function automatic stack_cmd_t pick_cmd(input int grow);
    stack_cmd_t c;
    int r;
    int f;
    int ecap;
    int hole;
    f    = stack_fill[PLAN];
    ecap = eff_cap(PLAN);
    c    = cmd_of(CMD_CLEAR, rand_word(), rand_word(), $urandom_range(0, 2047));
    r    = $urandom_range(0, 99);
    if (r < grow)      c.command = $urandom_range(0, 1) ? CMD_PUSH : CMD_PUSH2;
    else if (r < 70)   c.command = $urandom_range(0, 1) ? CMD_POP : CMD_POP2;
    else if (r < 76)   c.command = CMD_TOP;
    else if (r < 83)   c.command = CMD_GET;
    else if (r < 90)   c.command = CMD_SET;
    else if (r < 91)   c.command = CMD_CLEAR;
    else if (r < 96)   c.command = CMD_SET_SIZE;
    else               c.command = CMD_W'($urandom_range(CMD_UNKNOWN_LO, CMD_UNKNOWN_HI));

    if ((c.command == CMD_GET || c.command == CMD_SET) && $urandom_range(0, 7) != 0)
      c.position = SIZE_W'($urandom_range(0, f));
    if (c.command == CMD_SET_SIZE) begin
      case ($urandom_range(0, 7))
        0:       c.position = SIZE_W'(ecap);
        1:       c.position = SIZE_W'(ecap + 1);
        2:       c.position = SIZE_W'($urandom_range(0, 2047));
        default: c.position = SIZE_W'($urandom_range(0, ecap));
      endcase
    end

    hole = -1;
    if ((c.command == CMD_POP || c.command == CMD_TOP) && f >= 1 && !stack_written[PLAN][f-1])
      hole = f - 1;
    if (c.command == CMD_POP2 && f >= 2) begin
      if (!stack_written[PLAN][f-1])      hole = f - 1;
      else if (!stack_written[PLAN][f-2]) hole = f - 2;
    end
    if (c.command == CMD_GET && c.position < f && !stack_written[PLAN][c.position])
      hole = c.position;
    if (hole >= 0) begin
      c.command  = CMD_SET;
      c.position = SIZE_W'(hole);
    end
    return c;
  endfunction

  task automatic plan_cmd(input stack_cmd_t c);
    void'(stack_step(PLAN, c));
    cmd_backlog.push_back(c);
  endtask

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    if (errors <= 30)
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
  endtask

  task automatic wait_drain();
    do @(negedge clk);
    while (cmd_backlog.size() != 0 || start || answers_due.size() != 0);
  endtask

  task automatic write_capacity(input int cap);
    logic [31:0] word;
    word        = $urandom;
    word[10:0]  = cap[10:0];
    repeat (2) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_CAPACITY, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    stack_cap[PLAN]   = cap[10:0];
    stack_cap[MIRROR] = cap[10:0];
  endtask

  // Driver: one transfer per accepted command, random gaps between them while idle_on is set.
  always @(posedge clk) begin : drive
    logic next_start;
    next_start = start;
    if (start && !busy) begin
      answers_due.push_back(stack_step(MIRROR, on_port));
      n_sent++;
      next_start = 1'b0;
    end
    if (!next_start && !rst) begin
      if (gap_left > 0) gap_left--;
      else if (cmd_backlog.size() > 0) begin
        on_port   = cmd_backlog.pop_front();
        command  <= on_port.command;
        value_a  <= on_port.value_a;
        value_b  <= on_port.value_b;
        position <= on_port.position;
        next_start = 1'b1;
        gap_left   = pick_gap();
      end
    end
    start <= next_start;
  end

  // Monitor: results are registered, so mid-cycle sampling sees stable values.
  always @(negedge clk) begin : watch
    stack_result_t want;
    if (!rst && done) begin
      if (answers_due.size() == 0) report_mismatch("result with no command waiting", 1, 0);
      else begin
        want = answers_due.pop_front();
        n_results++;
        if (want.status) n_refused++;
        if (want.size_now > max_fill) max_fill = want.size_now;
        if (status !== want.status) report_mismatch("status", status, want.status);
        if (result_a !== want.result_a)
          report_mismatch("result_a", result_a, $signed(want.result_a));
        if (result_b !== want.result_b)
          report_mismatch("result_b", result_b, $signed(want.result_b));
        if (size_now !== want.size_now) report_mismatch("size_now", size_now, want.size_now);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : main
    int phase_cap  [NUM_PHASES];
    int phase_len  [NUM_PHASES];
    int phase_grow [NUM_PHASES];
    phase_cap  = '{1024, 0, 1, 2, 3, 2047, 1025, 5, 0, 1024, 17};
    phase_len  = '{120, 40, 60, 60, 80, 150, 100, 80, 100, 200, 135};
    phase_grow = '{50, 50, 45, 40, 35, 55, 45, 30, 40, 50, 35};
    phase_cap[8] = $urandom_range(0, 2047);
    model_reset(PLAN);
    model_reset(MIRROR);
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // empty stack refusals, extremes, pair ordering, range edges, full stack
    plan_cmd(cmd_of(CMD_TOP, 0, 0, 0));
    plan_cmd(cmd_of(CMD_POP, 0, 0, 0));
    plan_cmd(cmd_of(CMD_POP2, 0, 0, 0));
    plan_cmd(cmd_of(CMD_GET, 0, 0, 0));
    plan_cmd(cmd_of(CMD_SET, 32'h1234_5678, 0, 0));
    plan_cmd(cmd_of(CMD_PUSH, 32'h7fff_ffff, 32'hffff_ffff, 2047));
    plan_cmd(cmd_of(CMD_POP2, 0, 0, 0));
    plan_cmd(cmd_of(CMD_PUSH, 32'h8000_0000, 0, 0));
    plan_cmd(cmd_of(CMD_PUSH2, 32'h0, 32'hffff_ffff, 0));
    plan_cmd(cmd_of(CMD_TOP, 0, 0, 0));
    plan_cmd(cmd_of(CMD_GET, 0, 0, 0));
    plan_cmd(cmd_of(CMD_GET, 0, 0, 3));
    plan_cmd(cmd_of(CMD_GET, 0, 0, 4));
    plan_cmd(cmd_of(CMD_SET, 32'h5a5a_a5a5, 0, 2));
    plan_cmd(cmd_of(CMD_GET, 0, 0, 2));
    plan_cmd(cmd_of(CMD_POP2, 0, 0, 0));
    plan_cmd(cmd_of(CMD_POP, 0, 0, 0));
    plan_cmd(cmd_of(CMD_SET_SIZE, 0, 0, 2047));
    plan_cmd(cmd_of(CMD_SET_SIZE, 0, 0, 1025));
    plan_cmd(cmd_of(CMD_SET_SIZE, 0, 0, 1024));
    plan_cmd(cmd_of(CMD_PUSH, 32'h1, 0, 0));
    plan_cmd(cmd_of(CMD_PUSH2, 32'h2, 32'h3, 0));
    plan_cmd(cmd_of(CMD_SET, 32'hdead_beef, 0, 1023));
    plan_cmd(cmd_of(CMD_TOP, 0, 0, 0));
    plan_cmd(cmd_of(CMD_CLEAR, 0, 0, 0));
    plan_cmd(cmd_of(CMD_UNKNOWN_LO, 32'hffff_ffff, 32'hffff_ffff, 2047));
    plan_cmd(cmd_of(CMD_UNKNOWN_HI, 0, 0, 0));

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        // sender holds off until every outstanding result has come back
        wait_drain();
        write_capacity(phase_cap[ph]);
      end
      idle_on = (ph % 3 != 2);
      for (int n = 0; n < phase_len[ph]; n++) plan_cmd(pick_cmd(phase_grow[ph]));
    end

    wait_drain();
    repeat (4) @(posedge clk);
    $display("Covered %0d commands over %0d capacity settings, %0d refused, deepest stack %0d",
             n_sent, NUM_PHASES, n_refused, max_fill);
    $display("Checked %0d results in %0d cycles, %0d mismatches", n_results, cycles, errors);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
